[hdl/sha1s_pkg.sv]
// Shared types, constants and helper functions for the SHA-1 stream hasher.
`timescale 1ns / 1ps

package sha1s_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned FILL_W      = 6;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned LEN_W       = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] LEN_FILL  = 6'd56;
    localparam logic [FILL_W-1:0] LAST_FILL = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;

    localparam logic [WORD_W-1:0] IV [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    // working variables of the compression
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_t;

    // schedule window taps w[t], w[t+2], w[t+8], w[t+13]
    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w8;
        logic [WORD_W-1:0] w13;
    } taps_t;

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
        rotl1 = {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
        rotl5 = {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
        rotl30 = {v[1:0], v[WORD_W-1:2]};
    endfunction

endpackage

[hdl/sha1_stream_hasher.sv]
// Top level of the SHA-1 stream hasher: byte intake, padding sequencer, chaining state.
`timescale 1ns / 1ps
// Byte: the 64th byte of a block holds s_tready low through the round states and the
//   chaining add (ST_ROUND, then ST_ADD).
// Blocks: no new byte is taken until the single round unit has finished the last block.
// Finish: 9 to 72 pad and length bytes, one per cycle outside the compressions, one or two
//   compressions, then five digest words; s_tready stays low until the last word is taken.
// Reset (aresetn low, synchronous): initial chaining words, zero fill and count, idle.

module sha1_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] cmd: 0 byte, 1 finish

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    localparam int unsigned WIN_W = sha1s_pkg::BLOCK_BYTES * 8;
    localparam int unsigned W     = sha1s_pkg::WORD_W;

    sha1s_pkg::state_t state_reg, state_next;

    // 512-bit window: gathers bytes (first byte ends on top), then serves as the
    // 16-word schedule shift line during the rounds
    logic [WIN_W-1:0] win_reg, win_next;

    logic [W-1:0]                       h_reg   [sha1s_pkg::HASH_WORDS];
    logic [W-1:0]                       h_next  [sha1s_pkg::HASH_WORDS];
    sha1s_pkg::work_t                   work_reg, work_next, work_rnd;
    logic [sha1s_pkg::ROUND_W-1:0]      rnd_reg, rnd_next;
    logic [sha1s_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [sha1s_pkg::LEN_W-1:0]        count_reg, count_next;
    logic [sha1s_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [sha1s_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                               fin_reg, fin_next;        // finishing a message
    logic                               pad_first_reg, pad_first_next;
    logic                               len_phase_reg, len_phase_next;

    logic                               push;
    logic [7:0]                         push_byte;
    logic                               len_now;
    sha1s_pkg::taps_t                   taps;
    logic [W-1:0]                       sched_word;

    assign taps.w0  = win_reg[WIN_W-1        -: W];
    assign taps.w2  = win_reg[WIN_W-1 - 2*W  -: W];
    assign taps.w8  = win_reg[WIN_W-1 - 8*W  -: W];
    assign taps.w13 = win_reg[WIN_W-1 - 13*W -: W];

    sha1s_round u_round (
        .work_in    (work_reg),
        .taps       (taps),
        .rnd        (rnd_reg),
        .work_out   (work_rnd),
        .sched_word (sched_word)
    );

    assign len_now = len_phase_reg || (fill_reg == sha1s_pkg::LEN_FILL && !pad_first_reg);

    assign m_tvalid = (state_reg == sha1s_pkg::ST_EMIT);
    assign m_tdata  = h_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == sha1s_pkg::LAST_IDX);

    always_comb begin
        state_next     = state_reg;
        win_next       = win_reg;
        h_next         = h_reg;
        work_next      = work_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        s_tready       = 1'b0;
        push           = 1'b0;
        push_byte      = 8'h00;

        case (state_reg)
            sha1s_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        len_next       = {count_reg[sha1s_pkg::LEN_W-4:0], 3'b000};
                        fin_next       = 1'b1;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        state_next     = sha1s_pkg::ST_PAD;
                    end else begin
                        push       = 1'b1;
                        push_byte  = s_tdata;
                        count_next = count_reg + 64'd1;
                    end
                end
            end
            sha1s_pkg::ST_PAD: begin
                push = 1'b1;
                if (pad_first_reg) begin
                    push_byte      = sha1s_pkg::PAD_BYTE;
                    pad_first_next = 1'b0;
                end else if (len_now) begin
                    push_byte      = len_reg[sha1s_pkg::LEN_W-1 -: 8];
                    len_next       = {len_reg[sha1s_pkg::LEN_W-9:0], 8'h00};
                    len_phase_next = 1'b1;
                end
            end
            sha1s_pkg::ST_ROUND: begin
                work_next = work_rnd;
                win_next  = {win_reg[WIN_W-W-1:0], sched_word};
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == sha1s_pkg::LAST_ROUND) begin
                    state_next = sha1s_pkg::ST_ADD;
                end
            end
            sha1s_pkg::ST_ADD: begin
                h_next[0] = h_reg[0] + work_reg.a;
                h_next[1] = h_reg[1] + work_reg.b;
                h_next[2] = h_reg[2] + work_reg.c;
                h_next[3] = h_reg[3] + work_reg.d;
                h_next[4] = h_reg[4] + work_reg.e;
                if (!fin_reg) begin
                    state_next = sha1s_pkg::ST_IDLE;
                end else if (len_phase_reg) begin
                    idx_next   = '0;
                    state_next = sha1s_pkg::ST_EMIT;
                end else begin
                    state_next = sha1s_pkg::ST_PAD;
                end
            end
            sha1s_pkg::ST_EMIT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha1s_pkg::LAST_IDX) begin
                        h_next     = sha1s_pkg::IV;
                        count_next = '0;
                        fin_next   = 1'b0;
                        idx_next   = '0;
                        state_next = sha1s_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sha1s_pkg::ST_IDLE;
            end
        endcase

        // common byte path for message and pad bytes
        if (push) begin
            win_next  = {win_reg[WIN_W-9:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == sha1s_pkg::LAST_FILL) begin
                work_next.a = h_reg[0];
                work_next.b = h_reg[1];
                work_next.c = h_reg[2];
                work_next.d = h_reg[3];
                work_next.e = h_reg[4];
                rnd_next    = '0;
                state_next  = sha1s_pkg::ST_ROUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sha1s_pkg::ST_IDLE;
            h_reg         <= sha1s_pkg::IV;
            rnd_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            fin_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            rnd_reg       <= rnd_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            fin_reg       <= fin_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        work_reg <= work_next;
        len_reg  <= len_next;
    end

endmodule

[hdl/sha1s_round.sv]
// One SHA-1 round and one message schedule step; reused for all 80 rounds.
`timescale 1ns / 1ps

module sha1s_round (
    input  sha1s_pkg::work_t                    work_in,
    input  sha1s_pkg::taps_t                    taps,
    input  logic [sha1s_pkg::ROUND_W-1:0]       rnd,
    output sha1s_pkg::work_t                    work_out,
    output logic [sha1s_pkg::WORD_W-1:0]        sched_word
);

    logic [sha1s_pkg::WORD_W-1:0] f;
    logic [sha1s_pkg::WORD_W-1:0] k;
    logic [sha1s_pkg::WORD_W-1:0] sum;

    always_comb begin
        if (rnd < 7'd20) begin
            f = (work_in.b & work_in.c) | (~work_in.b & work_in.d);
            k = sha1s_pkg::K0;
        end else if (rnd < 7'd40) begin
            f = work_in.b ^ work_in.c ^ work_in.d;
            k = sha1s_pkg::K1;
        end else if (rnd < 7'd60) begin
            f = (work_in.b & work_in.c) | (work_in.b & work_in.d) | (work_in.c & work_in.d);
            k = sha1s_pkg::K2;
        end else begin
            f = work_in.b ^ work_in.c ^ work_in.d;
            k = sha1s_pkg::K3;
        end
        sum = sha1s_pkg::rotl5(work_in.a) + f + work_in.e + k + taps.w0;

        work_out.a = sum;
        work_out.b = work_in.a;
        work_out.c = sha1s_pkg::rotl30(work_in.b);
        work_out.d = work_in.c;
        work_out.e = work_in.d;

        // w[t+16]
        sched_word = sha1s_pkg::rotl1(taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0);
    end

endmodule

[hdl/sha1s_checker.sv]
// Port-level assertions for the SHA-1 stream hasher, bound to the top level.
`timescale 1ns / 1ps

module sha1s_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // no intake while the digest is going out
    a_no_intake_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest words pending");

    // last marker only on the fifth word
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd4)))
        else $error("last marker does not match word index");

    // words go out in order with no gap
    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("digest word index out of sequence");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);

[verif/tb_sha1_stream_hasher.sv]
// Testbench for sha1_stream_hasher: directed table plus random messages, checked by a SHA-1 predictor.
`timescale 1ns / 1ps

module tb_sha1_stream_hasher;

    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;
    localparam int   STALL_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int   TAIL_CYCLES = 200;
    localparam int   MAX_REPORTS = 10;

    // digest words in output order, word 0 (H0) first
    typedef logic [0:4][31:0] digest_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    typedef struct {
        logic        cmd;
        logic [7:0]  dbyte;
        bit          known;    // digest below is the literal answer
        digest_t     digest;
    } dir_row_t;

    localparam digest_t EMPTY_DIGEST =
        {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709};
    localparam digest_t ABC_DIGEST =
        {32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [31:0] sha_chain [5];
    logic [7:0]  sha_block [64];
    int unsigned sha_fill;
    logic [63:0] sha_len_bytes;

    digest_word_t digest_words_due [$];
    int  mismatches;
    int  stall_cycles;
    bit  calm;           // no idling on either side near the end
    int  tready_hold;

    dir_row_t dir_rows [14] = '{
        '{CMD_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // empty message right after reset
        '{CMD_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},   // data byte ignored on finish
        '{CMD_BYTE,   8'h61, 1'b0, '0},
        '{CMD_BYTE,   8'h62, 1'b0, '0},
        '{CMD_BYTE,   8'h63, 1'b0, '0},
        '{CMD_FINISH, 8'h00, 1'b1, ABC_DIGEST},
        '{CMD_BYTE,   8'h00, 1'b0, '0},
        '{CMD_BYTE,   8'hFF, 1'b0, '0},
        '{CMD_BYTE,   8'h80, 1'b0, '0},
        '{CMD_BYTE,   8'h7F, 1'b0, '0},
        '{CMD_FINISH, 8'h00, 1'b0, '0},
        '{CMD_BYTE,   8'h55, 1'b0, '0},
        '{CMD_BYTE,   8'hAA, 1'b0, '0},
        '{CMD_FINISH, 8'hA5, 1'b0, '0}
    };

    sha1_stream_hasher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void sha_init();
        sha_chain[0] = 32'h67452301;
        sha_chain[1] = 32'hEFCDAB89;
        sha_chain[2] = 32'h98BADCFE;
        sha_chain[3] = 32'h10325476;
        sha_chain[4] = 32'hC3D2E1F0;
        sha_fill = 0;
        sha_len_bytes = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {sha_block[4*r], sha_block[4*r+1], sha_block[4*r+2], sha_block[4*r+3]};
        for (int r = 16; r < 80; r++)
            w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
        a = sha_chain[0]; b = sha_chain[1]; c = sha_chain[2];
        d = sha_chain[3]; e = sha_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);          k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;                   k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;                   k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + w[r];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        sha_chain[0] += a; sha_chain[1] += b; sha_chain[2] += c;
        sha_chain[3] += d; sha_chain[4] += e;
    endfunction

    function automatic void sha_push(input logic [7:0] v);
        sha_block[sha_fill] = v;
        sha_fill = (sha_fill + 1) % 64;
        if (sha_fill == 0)
            sha_compress();
    endfunction

    // pad, compress what is left, hand back the digest and start a fresh message
    function automatic digest_t sha_finish();
        logic [63:0] bits;
        digest_t dg;
        bits = sha_len_bytes << 3;
        sha_push(8'h80);
        while (sha_fill != 56)
            sha_push(8'h00);
        for (int i = 0; i < 8; i++)
            sha_push(bits[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++)
            dg[i] = sha_chain[i];
        sha_init();
        return dg;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, what);
    endfunction

    // present one word, wait for the handshake, predict, then maybe idle a while
    task automatic drive_word(input logic cmd, input logic [7:0] dbyte,
                              input bit known, input digest_t typed);
        digest_t dg;
        s_tuser  = cmd;
        s_tdata  = dbyte;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (cmd == CMD_FINISH) begin
            dg = sha_finish();
            if (known)
                dg = typed;
            for (int i = 0; i < 5; i++)
                digest_words_due.push_back('{dg[i], 3'(i), i == 4});
        end else begin
            sha_len_bytes = sha_len_bytes + 64'd1;
            sha_push(dbyte);
        end
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
    endtask

    // result side: random back-pressure bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            tready_hold <= 0;
        end else if (tready_hold > 0) begin
            tready_hold <= tready_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            tready_hold <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // digest check against the oldest word still due
    always @(posedge aclk) begin
        digest_word_t due_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_words_due.size() == 0) begin
                note_mismatch($sformatf("unexpected digest word %08h idx %0d last %0b",
                                        m_tdata, m_tuser, m_tlast));
            end else begin
                due_w = digest_words_due.pop_front();
                if (m_tdata !== due_w.word || m_tuser !== due_w.idx
                        || m_tlast !== due_w.last)
                    note_mismatch($sformatf(
                        "digest word: expected %08h idx %0d last %0b, got %08h idx %0d last %0b",
                        due_w.word, due_w.idx, due_w.last, m_tdata, m_tuser, m_tlast));
            end
        end
    end

    // watchdog: any word moving on either side restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int boundary_len [2] = '{55, 56};
        int rnd_items;
        int rnd_msgs;
        int msg_len;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_BYTE;
        calm         = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        rnd_items    = 0;
        rnd_msgs     = 0;
        sha_init();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i])
            drive_word(dir_rows[i].cmd, dir_rows[i].dbyte, dir_rows[i].known,
                       dir_rows[i].digest);

        // hold off until every digest word of the directed part is out
        s_tvalid = 1'b0;
        while (digest_words_due.size() != 0)
            @(negedge aclk);

        // random messages; the first and the fourth sit on a padding boundary
        while (rnd_items < 130 || rnd_msgs < 6) begin
            if (rnd_msgs % 3 == 0 && rnd_msgs / 3 < 2)
                msg_len = boundary_len[rnd_msgs / 3];
            else
                msg_len = $urandom_range(0, 12);
            for (int k = 0; k < msg_len; k++)
                drive_word(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
            drive_word(CMD_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
            rnd_items += msg_len + 1;
            rnd_msgs++;
            if (rnd_msgs >= 4)
                calm = 1'b1;
        end

        s_tvalid = 1'b0;
        while (digest_words_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
